// File: rtl/rce_pkg.sv
package rce_pkg;

  // Alphabet and ASCII anchors
  localparam logic [4:0] ALPHA    = 5'd26;
  localparam logic [4:0] LAST_LTR = 5'd25;
  localparam logic [7:0] LETTER_A = 8'd65;
  localparam logic [7:0] LETTER_a = 8'd97;

  // Operation codes carried by an input word
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_POS  = 2'd1,
    OP_ENC  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  // Microprogram counter and step addresses
  typedef logic [2:0] upc_t;
  localparam upc_t UPC_PLUG_IN  = 3'd0;
  localparam upc_t UPC_FWD_RD   = 3'd1;
  localparam upc_t UPC_FWD_WB   = 3'd2;
  localparam upc_t UPC_REFL     = 3'd3;
  localparam upc_t UPC_INV_RD   = 3'd4;
  localparam upc_t UPC_INV_WB   = 3'd5;
  localparam upc_t UPC_PLUG_OUT = 3'd6;
  localparam upc_t UPC_PASS     = 3'd7;

  // Letter register source
  typedef enum logic [2:0] {
    L_HOLD,
    L_PLUG,
    L_FWD,
    L_REFL,
    L_INV
  } lsel_t;

  // Rotor counter operation
  typedef enum logic [2:0] {
    R_HOLD,
    R_CLR,
    R_INC,
    R_LAST,
    R_DEC
  } rop_t;

  // Sequencing of the step counter
  typedef enum logic [1:0] {
    J_NEXT,
    J_MORE_FWD,
    J_MORE_INV,
    J_END
  } jmp_t;

  typedef struct packed {
    lsel_t lsel;
    rop_t  rop;
    logic  rd_fwd;
    logic  rd_inv;
    jmp_t  jmp;
    upc_t  target;
    logic  done;
    logic  pass;
  } uword_t;

  // Control from sequencer to datapath
  typedef struct packed {
    uword_t uw;
    logic   fire;
  } ctrl_t;

  // Branch conditions from datapath to sequencer
  typedef struct packed {
    logic more_fwd;
    logic more_inv;
  } cond_t;

  localparam uword_t UW_NOP = '{lsel: L_HOLD, rop: R_HOLD, rd_fwd: 1'b0, rd_inv: 1'b0,
                                jmp: J_END, target: UPC_PLUG_IN, done: 1'b0, pass: 1'b0};

  // Control store
  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    w = UW_NOP;
    case (pc)
      UPC_PLUG_IN: begin
        w.lsel = L_PLUG; w.rop = R_CLR; w.jmp = J_NEXT;
      end
      UPC_FWD_RD: begin
        w.rd_fwd = 1'b1; w.jmp = J_NEXT;
      end
      UPC_FWD_WB: begin
        w.lsel = L_FWD; w.rop = R_INC; w.jmp = J_MORE_FWD; w.target = UPC_FWD_RD;
      end
      UPC_REFL: begin
        w.lsel = L_REFL; w.rop = R_LAST; w.jmp = J_NEXT;
      end
      UPC_INV_RD: begin
        w.rd_inv = 1'b1; w.jmp = J_NEXT;
      end
      UPC_INV_WB: begin
        w.lsel = L_INV; w.rop = R_DEC; w.jmp = J_MORE_INV; w.target = UPC_INV_RD;
      end
      UPC_PLUG_OUT: begin
        w.done = 1'b1; w.jmp = J_END;
      end
      UPC_PASS: begin
        w.done = 1'b1; w.pass = 1'b1; w.jmp = J_END;
      end
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

  // ASCII letter test, either case
  function automatic logic is_letter(logic [7:0] ch);
    return (ch >= LETTER_A && ch < LETTER_A + 8'(ALPHA)) ||
           (ch >= LETTER_a && ch < LETTER_a + 8'(ALPHA));
  endfunction

  // Fold a 5-bit letter index into 0..25
  function automatic logic [4:0] red26(logic [4:0] v);
    return (v >= ALPHA) ? v - ALPHA : v;
  endfunction

endpackage

// File: rtl/rce_ram.sv
module rce_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 78
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: rtl/rce_seq.sv
module rce_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start_letter,
  input  logic           start_pass,
  input  logic           out_free,
  input  rce_pkg::cond_t cond,
  output rce_pkg::ctrl_t ctrl,
  output logic           busy
);

  rce_pkg::upc_t   pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  rce_pkg::uword_t uw;
  logic            fire;

  // control word for the current step, NOP when idle
  always_comb begin
    uw   = busy_r ? rce_pkg::ucode_rom(pc_r) : rce_pkg::UW_NOP;
    fire = busy_r && uw.done && out_free;
  end

  // step counter and jumps
  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start_letter) begin
        pc_nxt   = rce_pkg::UPC_PLUG_IN;
        busy_nxt = 1'b1;
      end else if (start_pass) begin
        pc_nxt   = rce_pkg::UPC_PASS;
        busy_nxt = 1'b1;
      end
    end else begin
      case (uw.jmp)
        rce_pkg::J_NEXT:     pc_nxt = pc_r + 3'd1;
        rce_pkg::J_MORE_FWD: pc_nxt = cond.more_fwd ? uw.target : pc_r + 3'd1;
        rce_pkg::J_MORE_INV: pc_nxt = cond.more_inv ? uw.target : pc_r + 3'd1;
        rce_pkg::J_END:      if (fire) busy_nxt = 1'b0;
        default:             pc_nxt = pc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= rce_pkg::UPC_PLUG_IN;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign ctrl = '{uw: uw, fire: fire};
  assign busy = busy_r;

endmodule

// File: rtl/rce_datapath.sv
module rce_datapath #(
  parameter int NUM_ROTORS = 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic [1:0]     op,
  input  logic [2:0]     table_sel,
  input  logic [4:0]     entry_index,
  input  logic [4:0]     entry_value,
  input  logic [7:0]     char_in,
  input  rce_pkg::ctrl_t ctrl,
  output rce_pkg::cond_t cond,
  output logic [7:0]     result
);

  localparam int DEPTH = NUM_ROTORS * 26;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;

  logic [4:0]    l_r, l_nxt;
  logic [RW-1:0] r_r, r_nxt;
  logic [7:0]    ch_r;
  logic [4:0]    pos_r [NUM_ROTORS];
  logic [4:0]    pos_nxt [NUM_ROTORS];
  logic [4:0]    plug_r [26];
  logic [4:0]    refl_r [26];

  logic          in_rng, wr_rotor, wr_refl, wr_plug, wr_pos, step_rot;
  logic [AW-1:0] fwd_waddr, inv_waddr, fwd_raddr, inv_raddr;
  logic [4:0]    fwd_rdata, inv_rdata;
  logic [4:0]    l_red, pos_cur, fwd_off, inv_idx, plug_out;
  logic [5:0]    sum6, dif6;

  // write decode for load and position words
  always_comb begin
    in_rng   = (entry_index < rce_pkg::ALPHA) && (entry_value < rce_pkg::ALPHA);
    wr_rotor = acc && op == rce_pkg::OP_LOAD && in_rng && 4'(table_sel) < 4'(NUM_ROTORS);
    wr_refl  = acc && op == rce_pkg::OP_LOAD && in_rng && 4'(table_sel) == 4'(NUM_ROTORS);
    wr_plug  = acc && op == rce_pkg::OP_LOAD && in_rng && 4'(table_sel) == 4'(NUM_ROTORS + 1);
    wr_pos   = acc && op == rce_pkg::OP_POS && entry_value < rce_pkg::ALPHA &&
               4'(table_sel) < 4'(NUM_ROTORS);
    fwd_waddr = AW'(8'(table_sel) * 8'(rce_pkg::ALPHA) + 8'(entry_index));
    inv_waddr = AW'(8'(table_sel) * 8'(rce_pkg::ALPHA) + 8'(entry_value));
  end

  // letter arithmetic around the rotor offset
  always_comb begin
    l_red     = rce_pkg::red26(l_r);
    pos_cur   = pos_r[r_r];
    sum6      = {1'b0, l_red} + {1'b0, pos_cur};
    fwd_off   = (sum6 >= 6'(rce_pkg::ALPHA)) ? 5'(sum6 - 6'(rce_pkg::ALPHA)) : sum6[4:0];
    fwd_raddr = AW'(8'(r_r) * 8'(rce_pkg::ALPHA) + 8'(fwd_off));
    inv_raddr = AW'(8'(r_r) * 8'(rce_pkg::ALPHA) + 8'(l_red));
    inv_idx   = rce_pkg::red26(inv_rdata);
    dif6      = (inv_idx >= pos_cur) ? {1'b0, inv_idx} - {1'b0, pos_cur}
                                     : {1'b0, inv_idx} + 6'(rce_pkg::ALPHA) - {1'b0, pos_cur};
    plug_out  = rce_pkg::red26(plug_r[l_red]);
    result    = ctrl.uw.pass ? ch_r : rce_pkg::LETTER_A + 8'(plug_out);
    cond.more_fwd = (r_r != RW'(NUM_ROTORS - 1));
    cond.more_inv = (r_r != '0);
  end

  // letter register and rotor counter
  always_comb begin
    case (ctrl.uw.lsel)
      rce_pkg::L_PLUG: l_nxt = plug_r[l_red];
      rce_pkg::L_FWD:  l_nxt = fwd_rdata;
      rce_pkg::L_REFL: l_nxt = refl_r[l_red];
      rce_pkg::L_INV:  l_nxt = dif6[4:0];
      default:         l_nxt = l_r;
    endcase
    if (acc) begin
      l_nxt = 5'(char_in - (char_in >= rce_pkg::LETTER_a ? rce_pkg::LETTER_a
                                                         : rce_pkg::LETTER_A));
    end
    case (ctrl.uw.rop)
      rce_pkg::R_CLR:  r_nxt = '0;
      rce_pkg::R_INC:  r_nxt = r_r + 1'b1;
      rce_pkg::R_LAST: r_nxt = RW'(NUM_ROTORS - 1);
      rce_pkg::R_DEC:  r_nxt = r_r - 1'b1;
      default:         r_nxt = r_r;
    endcase
  end

  // odometer stepping after a letter, or a direct position write
  always_comb begin
    logic carry;
    carry    = 1'b1;
    step_rot = ctrl.fire && !ctrl.uw.pass;
    for (int i = 0; i < NUM_ROTORS; i++) begin
      pos_nxt[i] = pos_r[i];
      if (step_rot && carry) begin
        pos_nxt[i] = (pos_r[i] == rce_pkg::LAST_LTR) ? 5'd0 : pos_r[i] + 5'd1;
      end
      carry = carry && (pos_r[i] == rce_pkg::LAST_LTR);
      if (wr_pos && 4'(table_sel) == 4'(i)) begin
        pos_nxt[i] = entry_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ROTORS; i++) pos_r[i] <= 5'd0;
      for (int i = 0; i < 26; i++) plug_r[i] <= 5'(i);
    end else begin
      for (int i = 0; i < NUM_ROTORS; i++) pos_r[i] <= pos_nxt[i];
      if (wr_plug) plug_r[entry_index] <= entry_value;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    l_r <= l_nxt;
    r_r <= r_nxt;
    if (acc) ch_r <= char_in;
    if (wr_refl) refl_r[entry_index] <= entry_value;
  end

  // forward and inverse rotor wiring
  rce_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_fwd_ram (
    .clk   (clk),
    .we    (wr_rotor),
    .waddr (fwd_waddr),
    .wdata (entry_value),
    .re    (ctrl.uw.rd_fwd),
    .raddr (fwd_raddr),
    .rdata (fwd_rdata)
  );

  rce_ram #(.WIDTH(5), .DEPTH(DEPTH)) u_inv_ram (
    .clk   (clk),
    .we    (wr_rotor),
    .waddr (inv_waddr),
    .wdata (entry_index),
    .re    (ctrl.uw.rd_inv),
    .raddr (inv_raddr),
    .rdata (inv_rdata)
  );

endmodule

// File: rtl/rotor_cipher_engine.sv
// Rotor cipher engine. Load and position words are taken while it is idle and give
// no result. An encode word whose byte is not a letter returns it unchanged
// through the pass step, after which the next word can be taken.
// A letter runs a microprogram of 4*NUM_ROTORS+3 steps (15 for three rotors):
// one plugboard step, a read and a write-back step per rotor through the forward
// wiring RAM, a reflector step, a read and a write-back per rotor through the
// inverse wiring RAM, then the output step, which also steps the rotors. Its
// result is registered by the output step, and the next word can be taken once
// the output step has fired. The two-step pair comes from the registered RAM
// read port; the next word is held off by in_stall until the current one is
// finished, and a result still held by out_stall delays the output step by the
// cycles it waits. Rotor and reflector entries must be loaded before use; the
// plugboard starts out as the identity and all rotor positions start at zero.
module rotor_cipher_engine #(
  parameter int NUM_ROTORS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [2:0] in_table_sel,
  input  logic [4:0] in_entry_index,
  input  logic [4:0] in_entry_value,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out
);

  logic           acc, busy, out_free, start_letter, start_pass;
  rce_pkg::ctrl_t ctrl;
  rce_pkg::cond_t cond;
  logic [7:0]     result;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_char_r;

  // input handshake and start decode
  always_comb begin
    acc          = in_valid && !in_stall;
    start_letter = acc && in_op == rce_pkg::OP_ENC && rce_pkg::is_letter(in_char_in);
    start_pass   = acc && in_op == rce_pkg::OP_ENC && !rce_pkg::is_letter(in_char_in);
    out_free     = !out_valid_r || !out_stall;
    out_valid_nxt = ctrl.fire ? 1'b1 : (out_valid_r && out_stall);
  end

  assign in_stall = busy;

  rce_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_letter (start_letter),
    .start_pass   (start_pass),
    .out_free     (out_free),
    .cond         (cond),
    .ctrl         (ctrl),
    .busy         (busy)
  );

  rce_datapath #(.NUM_ROTORS(NUM_ROTORS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .op          (in_op),
    .table_sel   (in_table_sel),
    .entry_index (in_entry_index),
    .entry_value (in_entry_value),
    .char_in     (in_char_in),
    .ctrl        (ctrl),
    .cond        (cond),
    .result      (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) out_char_r <= result;
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;

endmodule

// File: rtl/rce_checker.sv
module rce_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char_out
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_out))
    else $error("result word changed while stalled");

  // an encode word makes the engine busy in the next cycle
  a_enc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == rce_pkg::OP_ENC |=> in_stall)
    else $error("encode word did not occupy the engine");

  // results only appear out of a busy engine
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // load and position words give no result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op != rce_pkg::OP_ENC && !out_valid |=> !out_valid)
    else $error("result produced by a non-encode word");

endmodule

bind rotor_cipher_engine rce_checker u_rce_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_op        (in_op),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_char_out (out_char_out)
);
